// ===== rtl/bam_pkg.sv =====
`default_nettype none
package bam_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_BLOCK  = 64;
    localparam int CFG_W      = 13;
    localparam int BLK_CFG_W  = 7;
    localparam int POS_W      = $clog2(MAX_WIDTH);
    localparam int IN_BLK_W   = $clog2(MAX_BLOCK);
    localparam int SUM_W      = 20;
    localparam int DIVS_W     = 13;
    localparam int NCH        = 3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK  = 2'd2;

    typedef struct packed {
        logic [7:0] pix_first;
        logic [7:0] pix_second;
        logic [7:0] pix_third;
    } in_t;

    typedef struct packed {
        logic [11:0] band_index;
        logic [11:0] block_column;
        logic [7:0]  mean_first;
        logic [7:0]  mean_second;
        logic [7:0]  mean_third;
        logic        frame_end;
    } out_t;

    typedef struct packed {
        logic accept;
        logic sum_wr;
        logic rem_start;
        logic mean_start;
        logic rem_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rem_ok;
        logic last_block;
        logic div_done;
        logic out_full;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/bam_div.sv =====
`default_nettype none
module bam_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bam_pkg::NCH-1:0][bam_pkg::SUM_W-1:0] dividend,
    input  wire logic [bam_pkg::DIVS_W-1:0]    divisor,
    output logic [bam_pkg::NCH-1:0][bam_pkg::SUM_W-1:0] quotient,
    output logic [bam_pkg::DIVS_W-1:0]         remainder,
    output logic                               done
);
    import bam_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [NCH-1:0][SUM_W-1:0]  q_reg, q_next;
    logic [NCH-1:0][DIVS_W-1:0] r_reg, r_next;
    logic [DIVS_W-1:0]          d_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg, done_reg;
    logic [DIVS_W:0]            t;

    // one quotient bit per lane per cycle, restoring
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            t = {r_reg[i], q_reg[i][SUM_W-1]};
            if (t >= {1'b0, d_reg}) begin
                r_next[i] = DIVS_W'(t - {1'b0, d_reg});
                q_next[i] = {q_reg[i][SUM_W-2:0], 1'b1};
            end else begin
                r_next[i] = t[DIVS_W-1:0];
                q_next[i] = {q_reg[i][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg[0];
    assign done      = done_reg;
endmodule
`default_nettype wire

// ===== rtl/bam_ctrl.sv =====
`default_nettype none
module bam_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          m_ready,
    input  wire bam_pkg::sts_t sts,
    output bam_pkg::cmd_t      cmd
);
    import bam_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_REM, ST_RD, ST_DIV, ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   can_load;

    assign can_load = !sts.out_full || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && sts.rem_ok;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (!sts.rem_ok) begin
                    cmd.rem_start = 1'b1;
                    state_next    = ST_REM;
                end else if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_REM: begin
                if (sts.div_done) begin
                    cmd.rem_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.sum_wr = 1'b1;
                if (sts.last_block) begin
                    cmd.mean_start = 1'b1;
                    state_next     = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    if (can_load) begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (can_load) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bam_dp.sv =====
`default_nettype none
module bam_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bam_pkg::in_t                s_data,
    input  wire logic                        m_ready,
    output logic                             m_valid,
    output bam_pkg::out_t                    m_data,
    input  wire logic                        cfg_valid,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [bam_pkg::CFG_W-1:0]   cfg_data,
    input  wire bam_pkg::cmd_t               cmd,
    output bam_pkg::sts_t                    sts
);
    import bam_pkg::*;

    localparam int MEM_W = NCH * SUM_W;

    // configuration
    logic [CFG_W-1:0]     width_reg, height_reg;
    logic [BLK_CFG_W-1:0] bsize_reg;
    logic [CFG_W-1:0]     w_eff, h_eff;
    logic [BLK_CFG_W-1:0] s_eff;
    logic                 cfg_hit;

    // position
    logic [POS_W-1:0]    col_reg, blk_reg, band_reg, rows_reg;
    logic [IN_BLK_W-1:0] cib_reg, rib_reg;
    logic [BLK_CFG_W-1:0] rem_h_reg;
    logic                rem_ok_reg;

    // per-item latches
    in_t                 px_reg;
    logic                first_reg, last_blk_reg, frame_end_reg;
    logic [POS_W-1:0]    blk_item_reg, band_item_reg;
    logic [DIVS_W-1:0]   count_reg;

    logic [MEM_W-1:0]    mem [MAX_WIDTH];
    logic [MEM_W-1:0]    rd_reg;

    logic [BLK_CFG_W-1:0] bh;
    logic                 last_col, last_rob, last_frame, blk_end;
    logic [NCH-1:0][SUM_W-1:0] sum_new, div_a;
    logic [NCH-1:0][7:0]  pxv;
    logic [DIVS_W-1:0]    div_d;
    logic [NCH-1:0][SUM_W-1:0] quot;
    logic [DIVS_W-1:0]    rem;
    logic                 div_done;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    always_comb begin
        w_eff = (width_reg == '0) ? CFG_W'(1)
              : (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg == '0) ? CFG_W'(1)
              : (height_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : height_reg;
        s_eff = (bsize_reg == '0) ? BLK_CFG_W'(1)
              : (bsize_reg > BLK_CFG_W'(MAX_BLOCK)) ? BLK_CFG_W'(MAX_BLOCK) : bsize_reg;
    end

    assign cfg_hit = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                                   || cfg_index == REG_BLOCK);

    // partial band sits first, rem_h rows high
    assign bh = (band_reg == '0 && rem_h_reg != '0) ? rem_h_reg : s_eff;
    assign last_col   = ({1'b0, col_reg} == w_eff - 1'b1);
    assign last_rob   = ({1'b0, rib_reg} == bh - 1'b1);
    assign last_frame = last_col && ({1'b0, rows_reg} == h_eff - 1'b1);
    assign blk_end    = last_col || ({1'b0, cib_reg} == s_eff - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            bsize_reg  <= BLK_CFG_W'(8);
            col_reg    <= '0;
            blk_reg    <= '0;
            band_reg   <= '0;
            rows_reg   <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            rem_ok_reg <= 1'b0;
        end else if (cfg_hit) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_BLOCK:  bsize_reg  <= cfg_data[BLK_CFG_W-1:0];
                default:    ;
            endcase
            col_reg    <= '0;
            blk_reg    <= '0;
            band_reg   <= '0;
            rows_reg   <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            rem_ok_reg <= 1'b0;
        end else begin
            if (cmd.rem_load) rem_ok_reg <= 1'b1;
            if (cmd.accept) begin
                if (last_frame) begin
                    col_reg  <= '0;
                    blk_reg  <= '0;
                    cib_reg  <= '0;
                    rib_reg  <= '0;
                    band_reg <= '0;
                    rows_reg <= '0;
                end else if (last_col) begin
                    col_reg  <= '0;
                    blk_reg  <= '0;
                    cib_reg  <= '0;
                    rows_reg <= rows_reg + 1'b1;
                    if (last_rob) begin
                        rib_reg  <= '0;
                        band_reg <= band_reg + 1'b1;
                    end else begin
                        rib_reg <= rib_reg + 1'b1;
                    end
                end else begin
                    col_reg <= col_reg + 1'b1;
                    if (blk_end) begin
                        cib_reg <= '0;
                        blk_reg <= blk_reg + 1'b1;
                    end else begin
                        cib_reg <= cib_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rem_load) rem_h_reg <= rem[BLK_CFG_W-1:0];
        if (cmd.accept) begin
            px_reg        <= s_data;
            first_reg     <= (rib_reg == '0) && (cib_reg == '0);
            last_blk_reg  <= last_rob && blk_end;
            frame_end_reg <= last_frame;
            blk_item_reg  <= blk_reg;
            band_item_reg <= band_reg;
            count_reg     <= (DIVS_W'(cib_reg) + DIVS_W'(1))
                           * (DIVS_W'(rib_reg) + DIVS_W'(1));
            rd_reg        <= mem[blk_reg];
        end
        if (cmd.sum_wr) mem[blk_item_reg] <= sum_new;
    end

    always_comb begin
        pxv[0] = px_reg.pix_first;
        pxv[1] = px_reg.pix_second;
        pxv[2] = px_reg.pix_third;
        for (int i = 0; i < NCH; i++) begin
            sum_new[i] = first_reg ? SUM_W'(pxv[i])
                       : rd_reg[i*SUM_W +: SUM_W] + SUM_W'(pxv[i]);
        end
        if (cmd.rem_start) begin
            div_a    = '0;
            div_a[0] = SUM_W'(h_eff);
            div_d    = DIVS_W'(s_eff);
        end else begin
            div_a = sum_new;
            div_d = count_reg;
        end
    end

    bam_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start || cmd.mean_start),
        .dividend  (div_a),
        .divisor   (div_d),
        .quotient  (quot),
        .remainder (rem),
        .done      (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.band_index   <= band_item_reg;
            m_data_reg.block_column <= blk_item_reg;
            m_data_reg.mean_first   <= quot[0][7:0];
            m_data_reg.mean_second  <= quot[1][7:0];
            m_data_reg.mean_third   <= quot[2][7:0];
            m_data_reg.frame_end    <= frame_end_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign sts.rem_ok     = rem_ok_reg;
    assign sts.last_block = last_blk_reg;
    assign sts.div_done   = div_done;
    assign sts.out_full   = m_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/block_average_mosaic_unit.sv =====
`default_nettype none
// Flow: a pixel that closes a block is summed, then the shared divider forms the means.
// Input: each pixel needs an accept state (sum read) and a write-back state; a closing
//   pixel holds the input while the 20-step divider runs and until the output is free.
// Reset: synchronous, active low; registers 640x480, block 8. After reset or a
//   register write, a divide finds height mod block before the first pixel.
module block_average_mosaic_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire bam_pkg::in_t              s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output bam_pkg::out_t                  m_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [bam_pkg::CFG_W-1:0] cfg_data
);
    import bam_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // register writes are always taken; writes to width, height or block restart the frame
    assign cfg_ready = 1'b1;

    // sequencer: remainder setup, accept, read-modify-write, divide, output
    bam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // counters, column sum memory, divider and output register
    bam_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule
`default_nettype wire
